[rtl/avcr_pkg.sv]
package avcr_pkg;

	// Frame geometry and level limits.
	localparam int unsigned FRAME_SAMPLES = 512;
	localparam int unsigned BIN_COUNT     = 256;
	localparam int unsigned MAX_COLUMNS   = 75;
	localparam int unsigned VOICE_COLUMNS = 17;
	localparam int unsigned LEVEL_MAX     = 15;
	localparam int unsigned VU_MAX        = 37;
	localparam int unsigned VU_SCALE      = 37;
	localparam int unsigned VOICE_MAX     = 37;
	localparam int unsigned SCOPE_MAX     = 12;
	localparam int unsigned SCOPE_BIAS    = 7;
	localparam int unsigned SCOPE_SPAN    = 74;
	localparam int unsigned COUNT_MAX     = 1023;

	// Scope step is (len << 8) / 74, done as len * ceil(2^25 / 74) >> 17.
	// The reciprocal error stays below the exactness bound for len <= 512.
	localparam int unsigned RECIP_SHIFT = 17;
	localparam int unsigned RECIP_MUL   = ((1 << 25) + SCOPE_SPAN - 1) / SCOPE_SPAN;

	// Display modes.
	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_ANALYZER = 2'd1;
	localparam logic [1:0] MODE_VOICE    = 2'd2;
	localparam logic [1:0] MODE_SCOPE    = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_VIS_MODE  = 2'd0;
	localparam logic [1:0] REG_BAR_STYLE = 2'd1;
	localparam logic [1:0] REG_SHADED    = 2'd2;
	localparam logic [1:0] REG_VISIBLE   = 2'd3;

	localparam logic [7:0] FINE_EDGES [0:76] = '{
		8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
		8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19,
		8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29,
		8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39,
		8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49,
		8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd61,
		8'd66, 8'd71, 8'd76, 8'd81, 8'd87, 8'd93, 8'd100, 8'd107, 8'd114, 8'd122,
		8'd131, 8'd140, 8'd150, 8'd161, 8'd172, 8'd184, 8'd255
	};

	localparam logic [7:0] COARSE_EDGES [0:20] = '{
		8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11,
		8'd15, 8'd20, 8'd27, 8'd36, 8'd47, 8'd62, 8'd82, 8'd107, 8'd141, 8'd184,
		8'd255
	};

	// Thresholds of floor(ln(y) * 3.6067), clamped to 15.
	localparam logic [7:0] LOG_STEPS [0:14] = '{
		8'd2, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd10, 8'd13, 8'd17,
		8'd22, 8'd28, 8'd37, 8'd49, 8'd65
	};

	typedef struct packed {
		logic [1:0] vis_mode;
		logic       bar_style;
		logic       shaded;
		logic       visible;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               channel;
		logic               stereo;
		logic [9:0]         frame_length;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [6:0] column;
		logic [5:0] level;
		logic       last_of_frame;
	} result_t;

	// One queue entry holds everything that one item causes.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	function automatic logic [7:0] fine_edge(input logic [6:0] i);
		return (i < 7'd77) ? FINE_EDGES[i] : 8'hFF;
	endfunction

	function automatic logic [7:0] coarse_edge(input logic [6:0] i);
		return (i < 7'd21) ? COARSE_EDGES[i[4:0]] : 8'hFF;
	endfunction

	function automatic logic [3:0] log_level(input logic [7:0] y);
		logic [3:0] lvl;
		lvl = '0;
		for (int i = 0; i < LEVEL_MAX; i++) begin
			lvl = lvl + 4'(y >= LOG_STEPS[i]);
		end
		return lvl;
	endfunction

	function automatic logic [5:0] vu_level(input logic [15:0] peak);
		logic [21:0] prod;
		logic [6:0]  v;
		prod = 22'(peak) * 22'(VU_SCALE);
		v    = prod[21:15];
		return (v > 7'(VU_MAX)) ? 6'(VU_MAX) : v[5:0];
	endfunction

endpackage

[rtl/avcr_front.sv]
module avcr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  avcr_pkg::cfg_t    cfg,
	input  logic              accept,
	input  avcr_pkg::item_t   item,
	output logic              push,
	output avcr_pkg::entry_t  entry
);

	// Frame state.
	logic [9:0]  count_q, count_d;
	logic [6:0]  band_q, band_d;
	logic [14:0] peak_q, peak_d;
	logic [15:0] chpk0_q, chpk0_d;
	logic [15:0] chpk1_q, chpk1_d;
	logic [15:0] step_q, step_d;
	logic [17:0] pos_q, pos_d;
	logic [8:0]  last_idx_q, last_idx_d;

	logic                 emit0, emit1;
	avcr_pkg::result_t    r0, r1;

	logic [14:0] pos_sample;
	logic [15:0] abs_sample;
	logic [6:0]  band_inc;
	logic [6:0]  ncols;
	logic [7:0]  edge_v;
	logic [14:0] cand_peak;
	logic [15:0] vu_p0, vu_p1;
	logic        is_vu;
	logic [8:0]  voice_th;
	logic [9:0]  voice_raw;
	logic [5:0]  voice_lv;
	logic [9:0]  scope_len;
	logic [28:0] recip_prod;
	logic [15:0] step_new;
	logic [4:0]  scope_v;
	logic [5:0]  scope_lv;
	logic [17:0] pos_b, pos_c;
	logic [9:0]  idx_a, idx_b;

	assign pos_sample = item.sample[15] ? 15'd0 : item.sample[14:0];
	assign abs_sample = item.sample[15] ? 16'(~item.sample + 16'sd1) : 16'(item.sample);
	assign band_inc   = band_q + 7'd1;
	assign is_vu      = cfg.shaded && cfg.visible;

	// Analyzer layout and band edge of the current column.
	always_comb begin
		if (cfg.bar_style) begin
			ncols  = cfg.shaded ? 7'd13 : 7'd19;
			edge_v = avcr_pkg::coarse_edge(band_inc);
		end else begin
			ncols  = cfg.shaded ? 7'd37 : 7'(avcr_pkg::MAX_COLUMNS);
			edge_v = avcr_pkg::fine_edge(band_inc);
		end
	end

	assign cand_peak = (pos_sample > peak_q) ? pos_sample : peak_q;

	// Channel peaks including this sample.
	always_comb begin
		vu_p0 = chpk0_q;
		vu_p1 = chpk1_q;
		if (count_q < 10'(avcr_pkg::FRAME_SAMPLES)) begin
			if (!item.channel && abs_sample > chpk0_q) begin
				vu_p0 = abs_sample;
			end
			if (item.channel && abs_sample > chpk1_q) begin
				vu_p1 = abs_sample;
			end
		end
	end

	// Voiceprint: column k sits on bin floor(3k/2).
	assign voice_th  = 9'(({2'b00, band_q} + {1'b0, band_q, 1'b0}) >> 1);
	assign voice_raw = item.sample[14:5];
	assign voice_lv  = item.sample[15] ? 6'd0 :
		(voice_raw > 10'(avcr_pkg::VOICE_MAX)) ? 6'(avcr_pkg::VOICE_MAX) : voice_raw[5:0];

	// Scope decimation step from the frame length of item 0.
	always_comb begin
		if (item.frame_length < 10'(avcr_pkg::SCOPE_SPAN)) begin
			scope_len = 10'(avcr_pkg::SCOPE_SPAN);
		end else if (item.frame_length > 10'(avcr_pkg::FRAME_SAMPLES)) begin
			scope_len = 10'(avcr_pkg::FRAME_SAMPLES);
		end else begin
			scope_len = item.frame_length;
		end
	end

	assign recip_prod = 29'(scope_len) * 29'(avcr_pkg::RECIP_MUL);
	assign step_new   = 16'(recip_prod >> avcr_pkg::RECIP_SHIFT);

	// Arithmetic shift by 12 plus bias, then clamp to the scope range.
	assign scope_v  = {item.sample[15], item.sample[15:12]} + 5'(avcr_pkg::SCOPE_BIAS);
	assign scope_lv = scope_v[4] ? 6'd0 :
		(scope_v > 5'(avcr_pkg::SCOPE_MAX)) ? 6'(avcr_pkg::SCOPE_MAX) : {2'b00, scope_v[3:0]};

	assign pos_b = pos_q + {2'b00, step_q};
	assign pos_c = pos_q + {1'b0, step_q, 1'b0};
	assign idx_a = (pos_q[17:8] > {1'b0, last_idx_q}) ? {1'b0, last_idx_q} : pos_q[17:8];
	assign idx_b = (pos_b[17:8] > {1'b0, last_idx_q}) ? {1'b0, last_idx_q} : pos_b[17:8];

	always_comb begin
		emit0      = 1'b0;
		emit1      = 1'b0;
		r0         = '0;
		r1         = '0;
		count_d    = count_q;
		band_d     = band_q;
		peak_d     = peak_q;
		chpk0_d    = chpk0_q;
		chpk1_d    = chpk1_q;
		step_d     = step_q;
		pos_d      = pos_q;
		last_idx_d = last_idx_q;

		unique case (cfg.vis_mode)
			avcr_pkg::MODE_ANALYZER: begin
				if (count_q < 10'(avcr_pkg::BIN_COUNT) && band_q < ncols) begin
					peak_d = cand_peak;
					if ({1'b0, count_q} + 11'd1 >= {3'b000, edge_v}) begin
						emit0            = 1'b1;
						r0.column        = band_q;
						r0.level         = {2'b00, avcr_pkg::log_level(cand_peak[14:7])};
						r0.last_of_frame = (band_q == ncols - 7'd1);
						band_d           = band_inc;
						peak_d           = '0;
					end
				end
			end
			avcr_pkg::MODE_VOICE: begin
				if (is_vu) begin
					chpk0_d = vu_p0;
					chpk1_d = vu_p1;
					if (item.last) begin
						emit0            = 1'b1;
						emit1            = 1'b1;
						r0.column        = 7'd0;
						r0.level         = avcr_pkg::vu_level(vu_p0);
						r0.last_of_frame = 1'b0;
						r1.column        = 7'd1;
						r1.level         = avcr_pkg::vu_level(item.stereo ? vu_p1 : vu_p0);
						r1.last_of_frame = 1'b1;
					end
				end else if (count_q < 10'(avcr_pkg::BIN_COUNT) &&
						band_q < 7'(avcr_pkg::VOICE_COLUMNS) &&
						count_q >= {1'b0, voice_th}) begin
					emit0            = 1'b1;
					r0.column        = band_q;
					r0.level         = voice_lv;
					r0.last_of_frame = (band_q == 7'(avcr_pkg::VOICE_COLUMNS - 1));
					band_d           = band_inc;
				end
			end
			avcr_pkg::MODE_SCOPE: begin
				r0.column        = band_q;
				r0.level         = scope_lv;
				r0.last_of_frame = (band_q == 7'(avcr_pkg::MAX_COLUMNS - 1));
				r1.column        = band_inc;
				r1.level         = scope_lv;
				r1.last_of_frame = (band_inc == 7'(avcr_pkg::MAX_COLUMNS - 1));
				if (count_q == '0) begin
					// Frame start: position is zero, so only column 0 can fall here.
					step_d     = step_new;
					last_idx_d = 9'(scope_len - 10'd1);
					if (band_q < 7'(avcr_pkg::MAX_COLUMNS)) begin
						emit0  = 1'b1;
						band_d = band_inc;
						pos_d  = 18'(step_new);
					end else begin
						pos_d = '0;
					end
				end else begin
					emit0 = (band_q < 7'(avcr_pkg::MAX_COLUMNS)) && (idx_a <= count_q);
					emit1 = emit0 && (band_inc < 7'(avcr_pkg::MAX_COLUMNS)) &&
						(idx_b <= count_q);
					if (emit1) begin
						band_d = band_q + 7'd2;
						pos_d  = pos_c;
					end else if (emit0) begin
						band_d = band_inc;
						pos_d  = pos_b;
					end
				end
			end
			avcr_pkg::MODE_OFF: begin
			end
		endcase

		if (item.last) begin
			count_d = '0;
			band_d  = '0;
			peak_d  = '0;
			chpk0_d = '0;
			chpk1_d = '0;
			pos_d   = '0;
		end else if (count_q < 10'(avcr_pkg::COUNT_MAX)) begin
			count_d = count_q + 10'd1;
		end
	end

	assign push        = accept && emit0;
	assign entry.two   = emit1;
	assign entry.r0    = r0;
	assign entry.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			band_q     <= '0;
			peak_q     <= '0;
			chpk0_q    <= '0;
			chpk1_q    <= '0;
			step_q     <= '0;
			pos_q      <= '0;
			last_idx_q <= '0;
		end else if (accept) begin
			count_q    <= count_d;
			band_q     <= band_d;
			peak_q     <= peak_d;
			chpk0_q    <= chpk0_d;
			chpk1_q    <= chpk1_d;
			step_q     <= step_d;
			pos_q      <= pos_d;
			last_idx_q <= last_idx_d;
		end
	end

endmodule

[rtl/avcr_queue.sv]
module avcr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  avcr_pkg::entry_t  wdata,
	input  logic              pop,
	output logic              full,
	output logic              valid,
	output avcr_pkg::entry_t  head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	avcr_pkg::entry_t mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/avcr_back.sv]
module avcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  avcr_pkg::entry_t  q_head,
	output logic              q_pop,
	output logic              m_valid,
	input  logic              m_ready,
	output avcr_pkg::result_t m_res
);

	logic              sel_q;
	logic              valid_q;
	avcr_pkg::result_t res_q;
	logic              load;

	// Load a new result whenever the output register is empty or drains.
	assign load  = q_valid && (!valid_q || m_ready);
	assign q_pop = load && (sel_q || !q_head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !sel_q && q_head.two;
			end else if (m_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= sel_q ? q_head.r1 : q_head.r0;
		end
	end

	assign m_valid = valid_q;
	assign m_res   = res_q;

endmodule

[rtl/audio_vis_column_reducer.sv]
// Audio visualization column reducer.
// Input stream (s_*): one spectrum bin or PCM sample per transfer, in frame order,
// with s_tlast on the final item of a frame. Output stream (m_*): one display
// column level per transfer, m_tlast on the final column of a complete layout.
// Configuration (cfg_we, cfg_index, cfg_data) selects off, analyzer, voiceprint
// or vu, and scope modes and the analyzer layout; write it only while idle.
// Throughput: one input transfer per cycle while the queue has room. The front
// end classifies and reduces each item combinationally and posts the one or two
// columns it causes into a small queue; the back end emits one column per cycle
// while m_tready is high, so the output port and its single result register bound
// the rate when items cause two columns. Path: a column is written into the queue
// at the input transfer edge and then loaded into the output register that drives
// m_tvalid, without waiting when the queue is empty and the output free.
// Stall: when m_tready stays low the output register holds, the queue fills and
// s_tready drops once QUEUE_DEPTH entries wait. Items that cause no column do
// not occupy the queue.
// Reset: all frame counters, peaks and the queue clear; the mode returns to
// analyzer with the fine layout, unshaded and visible.
module audio_vis_column_reducer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] sample, [25:16] frame_length, rest zero
	input  logic [1:0]  s_tuser,   // [0] channel, [1] stereo
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] column, [12:7] level, rest zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	avcr_pkg::cfg_t    cfg_q;
	avcr_pkg::item_t   item;
	avcr_pkg::entry_t  q_wdata, q_head;
	avcr_pkg::result_t m_res;
	logic              accept, q_push, q_pop, q_full, q_valid;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vis_mode  <= avcr_pkg::MODE_ANALYZER;
			cfg_q.bar_style <= 1'b0;
			cfg_q.shaded    <= 1'b0;
			cfg_q.visible   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				avcr_pkg::REG_VIS_MODE:  cfg_q.vis_mode  <= cfg_data;
				avcr_pkg::REG_BAR_STYLE: cfg_q.bar_style <= cfg_data[0];
				avcr_pkg::REG_SHADED:    cfg_q.shaded    <= cfg_data[0];
				avcr_pkg::REG_VISIBLE:   cfg_q.visible   <= cfg_data[0];
			endcase
		end
	end

	// An item is taken whenever the queue has room, even if the output is stalled.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	assign item.sample       = s_tdata[15:0];
	assign item.frame_length = s_tdata[25:16];
	assign item.channel      = s_tuser[0];
	assign item.stereo       = s_tuser[1];
	assign item.last         = s_tlast;

	avcr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.item   (item),
		.push   (q_push),
		.entry  (q_wdata)
	);

	avcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.head   (q_head)
	);

	avcr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (m_res)
	);

	assign m_tdata = {3'b000, m_res.level, m_res.column};
	assign m_tlast = m_res.last_of_frame;

	// The front end never posts into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("column queue overflow");

	// The back end only takes entries that are there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("column queue underflow");

	// A waiting entry reaches an idle output register in the next cycle.
	a_output_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !m_tvalid) |=> m_tvalid)
		else $error("output register did not load a waiting column");

endmodule
